// ===== design/cd_pkg.sv =====
// Shared constants, types and command codes of the circular deque.
package cd_pkg;

  localparam int DEPTH   = 64;
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 3;
  localparam int CAP_W   = 7;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = ((ADDR_W + 1) > CAP_W) ? (ADDR_W + 1) : CAP_W;
  localparam int CAP_MAX = (DEPTH > ((2 ** CAP_W) - 1)) ? ((2 ** CAP_W) - 1) : DEPTH;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CAP_W-1:0] cap_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_e;

endpackage

// ===== design/cd_intf.sv =====
// Handshake interfaces for the command, response and configuration channels.
interface cd_cmd_if;
  import cd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic signed [DATA_W-1:0] value;
  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface cd_rsp_if;
  import cd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic                     is_empty;
  logic                     is_full;
  modport source (output valid, output accepted, output front_value, output back_value,
                  output is_empty, output is_full, input ready);
  modport sink (input valid, input accepted, input front_value, input back_value,
                input is_empty, input is_full, output ready);
endinterface

interface cd_cfg_if;
  import cd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;
  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

// ===== design/cd_ring_ram.sv =====
// Ring store: one write port and two registered read ports.
module cd_ring_ram (
  input  logic          clk_i,
  input  logic          we_i,
  input  cd_pkg::addr_t waddr_i,
  input  cd_pkg::data_t wdata_i,
  input  logic          re_i,
  input  cd_pkg::addr_t raddr_a_i,
  input  cd_pkg::addr_t raddr_b_i,
  output cd_pkg::data_t rdata_a_o,
  output cd_pkg::data_t rdata_b_o
);
  import cd_pkg::*;

  data_t mem_q [DEPTH];
  data_t rdata_a_q;
  data_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/circular_deque.sv =====
// Circular deque top level: pointer control, command sequencing and response register.
// A command's response becomes valid in S_RESP: the store write and pointer update happen
// at the transfer, then the front and back entries are read in S_READ.
// One command is in flight at a time; a new command is taken only in S_IDLE, once the
// response of the last one has transferred after the write-then-read on the ring store.
// Reset empties the queue and sets the capacity to the full depth; store contents stay.
module circular_deque (
  input  logic clk_i,
  input  logic rst_ni,
  cd_cmd_if.sink   cmd_i,
  cd_cfg_if.sink   cfg_i,
  cd_rsp_if.source rsp_o
);
  import cd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_e;

  state_e state_q;
  cap_t   cap_q;
  addr_t  head_q, tail_q;
  logic   empty_q;
  logic   ok_q;

  addr_t  head_d, tail_d;
  logic   empty_d;
  logic   ok_d;
  logic   we;
  addr_t  waddr;
  cmd_e   cmd;

  logic [CNT_W-1:0] cap_w, head_w, tail_w;
  addr_t  head_inc, head_dec, tail_inc, tail_dec;
  logic   full;
  cap_t   cap_new;
  data_t  rdata_a, rdata_b;

  logic   cmd_xfer, cfg_xfer;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;
  assign cfg_xfer    = cfg_i.valid && cfg_i.ready;

  assign cap_w  = CNT_W'(cap_q);
  assign head_w = CNT_W'(head_q);
  assign tail_w = CNT_W'(tail_q);

  assign head_inc = ((head_w + 1'b1) == cap_w) ? '0 : ADDR_W'(head_w + 1'b1);
  assign tail_inc = ((tail_w + 1'b1) == cap_w) ? '0 : ADDR_W'(tail_w + 1'b1);
  assign head_dec = (head_w == '0) ? ADDR_W'(cap_w - 1'b1) : ADDR_W'(head_w - 1'b1);
  assign tail_dec = (tail_w == '0) ? ADDR_W'(cap_w - 1'b1) : ADDR_W'(tail_w - 1'b1);
  assign full     = !empty_q && (tail_inc == head_q);

  always_comb begin
    if (cfg_i.capacity == '0) begin
      cap_new = CAP_W'(1);
    end else if (int'(cfg_i.capacity) > CAP_MAX) begin
      cap_new = CAP_W'(CAP_MAX);
    end else begin
      cap_new = cfg_i.capacity;
    end
  end

  always_comb begin
    cmd     = cmd_e'(cmd_i.command);
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    ok_d    = 1'b0;
    we      = 1'b0;
    waddr   = head_q;
    case (cmd)
      CMD_NONE: begin
        ok_d = 1'b1;
      end
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (!full) begin
          ok_d = 1'b1;
          we   = cmd_xfer;
          if (empty_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b0;
            waddr   = '0;
          end else if (cmd == CMD_PUSH_FRONT) begin
            head_d = head_dec;
            waddr  = head_dec;
          end else begin
            tail_d = tail_inc;
            waddr  = tail_inc;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (!empty_q) begin
          ok_d = 1'b1;
          if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else if (cmd == CMD_POP_FRONT) begin
            head_d = head_inc;
          end else begin
            tail_d = tail_dec;
          end
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= CAP_W'(CAP_MAX);
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      ok_q    <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        cap_q   <= cap_new;
        head_q  <= '0;
        tail_q  <= '0;
        empty_q <= 1'b1;
      end else if (cmd_xfer) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        empty_q <= empty_d;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_xfer) begin
            ok_q    <= ok_d;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (rsp_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  cd_ring_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (cmd_i.value),
    .re_i      (state_q == S_READ),
    .raddr_a_i (head_q),
    .raddr_b_i (tail_q),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign rsp_o.valid       = (state_q == S_RESP);
  assign rsp_o.accepted    = ok_q;
  assign rsp_o.front_value = empty_q ? '1 : rdata_a;
  assign rsp_o.back_value  = empty_q ? '1 : rdata_b;
  assign rsp_o.is_empty    = empty_q;
  assign rsp_o.is_full     = full;

  a_xfer_then_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_xfer |=> (state_q == S_READ))
    else $error("Command transfer was not followed by the store read.");

  a_ptr_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W'(head_q) < cap_w) && (CNT_W'(tail_q) < cap_w))
    else $error("Ring pointer lies outside the capacity in use.");

  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> ((head_q == '0) && (tail_q == '0)))
    else $error("Empty queue with nonzero pointers.");

  a_resp_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready && !cfg_xfer) |=>
      ($stable(rsp_o.front_value) && $stable(rsp_o.back_value)))
    else $error("Pending response data changed.");

endmodule

// ===== tb/tb_circular_deque.sv =====
// Self-checking testbench for the circular deque: command traffic, capacity settings and handshakes.
module tb_circular_deque;
  timeunit 1ns;
  timeprecision 1ps;

  import cd_pkg::*;

  typedef struct {
    logic  accepted;
    data_t front_value;
    data_t back_value;
    logic  is_empty;
    logic  is_full;
  } deque_status_t;

  localparam data_t EMPTY_WORD = -1;
  localparam int    MAX_GAP    = 200;

  logic clk;
  logic rst_n;

  cd_cmd_if cmd_if ();
  cd_cfg_if cfg_if ();
  cd_rsp_if rsp_if ();

  circular_deque i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .cfg_i (cfg_if),
    .rsp_o (rsp_if)
  );

  data_t       ring_copy [DEPTH];
  int unsigned head_pos;
  int unsigned tail_pos;
  bit          queue_empty;
  cap_t        capacity_reg;

  deque_status_t pending_status_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int recv_hold_cycles;
  int mismatches;
  int commands_sent;
  int statuses_checked;
  int refused_count;
  int full_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("circular_deque: mismatch");
    $finish;
  end

  function automatic int unsigned ring_size();
    if (capacity_reg == '0) return 1;
    if (capacity_reg > DEPTH) return DEPTH;
    return capacity_reg;
  endfunction

  function automatic bit ring_full();
    return !queue_empty && ((tail_pos + 1) % ring_size()) == head_pos;
  endfunction

  function automatic void clear_ring();
    head_pos    = 0;
    tail_pos    = 0;
    queue_empty = 1'b1;
  endfunction

  function automatic deque_status_t deque_after_command(input logic [CMD_W-1:0] cmd,
                                                        input data_t word);
    deque_status_t st;
    int unsigned   n;
    n           = ring_size();
    st.accepted = 1'b0;
    case (cmd)
      CMD_NONE: begin
        st.accepted = 1'b1;
      end
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (!ring_full()) begin
          if (queue_empty) begin
            head_pos    = 0;
            tail_pos    = 0;
            queue_empty = 1'b0;
          end else if (cmd == CMD_PUSH_FRONT) begin
            head_pos = (head_pos + n - 1) % n;
          end else begin
            tail_pos = (tail_pos + 1) % n;
          end
          ring_copy[(cmd == CMD_PUSH_FRONT ? head_pos : tail_pos) % DEPTH] = word;
          st.accepted = 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (!queue_empty) begin
          if (head_pos == tail_pos) clear_ring();
          else if (cmd == CMD_POP_FRONT) head_pos = (head_pos + 1) % n;
          else tail_pos = (tail_pos + n - 1) % n;
          st.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
    st.front_value = queue_empty ? EMPTY_WORD : ring_copy[head_pos % DEPTH];
    st.back_value  = queue_empty ? EMPTY_WORD : ring_copy[tail_pos % DEPTH];
    st.is_empty    = queue_empty;
    st.is_full     = ring_full();
    return st;
  endfunction

  function automatic int idle_cycles(input int pct);
    int n;
    n = 0;
    while (n < MAX_GAP && $urandom_range(0, 99) < pct) n++;
    return n;
  endfunction

  task automatic report_mismatch(input string what, input data_t got, input data_t want);
    if (mismatches < 40)
      $display("[%0t] status %0d: %s is %0d, expected %0d", $time, statuses_checked, what,
               got, want);
    mismatches++;
  endtask

  task automatic check_status();
    deque_status_t want;
    if (pending_status_q.size() == 0) begin
      report_mismatch("unexpected transfer, pending count", 1, 0);
      return;
    end
    want = pending_status_q.pop_front();
    if (rsp_if.accepted !== want.accepted)
      report_mismatch("accepted", data_t'(rsp_if.accepted), data_t'(want.accepted));
    if (rsp_if.front_value !== want.front_value)
      report_mismatch("front_value", rsp_if.front_value, want.front_value);
    if (rsp_if.back_value !== want.back_value)
      report_mismatch("back_value", rsp_if.back_value, want.back_value);
    if (rsp_if.is_empty !== want.is_empty)
      report_mismatch("is_empty", data_t'(rsp_if.is_empty), data_t'(want.is_empty));
    if (rsp_if.is_full !== want.is_full)
      report_mismatch("is_full", data_t'(rsp_if.is_full), data_t'(want.is_full));
    statuses_checked++;
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) check_status();
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input data_t word);
    deque_status_t st;
    int            gap;
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= cmd;
    cmd_if.value   <= word;
    do @(posedge clk); while (!cmd_if.ready);
    st = deque_after_command(cmd, word);
    pending_status_q.push_back(st);
    commands_sent++;
    if (!st.accepted) refused_count++;
    if (st.is_full) full_count++;
    gap = idle_cycles(send_idle_pct);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic release_sender();
    cmd_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input cap_t cap);
    release_sender();
    wait_drained();
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= cap;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    capacity_reg = cap;
    clear_ring();
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic data_t random_word();
    case ($urandom_range(0, 15))
      0: return data_t'(32'h7fff_ffff);
      1: return data_t'(32'h8000_0000);
      2: return EMPTY_WORD;
      3: return '0;
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_random_command(input int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      if ($urandom_range(0, 1)) send_command(CMD_NONE, random_word());
      else send_command(CMD_W'($urandom_range(CMD_POP_BACK + 1, 2 ** CMD_W - 1)),
                        random_word());
    end else if (r < 4 + push_pct) begin
      send_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, random_word());
    end else begin
      send_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, random_word());
    end
  endtask

  task automatic run_traffic(input int count, input cap_t cap);
    int left;
    int burst;
    int push_pct;
    write_capacity(cap);
    left = count;
    while (left > 0) begin
      push_pct = $urandom_range(0, 1) ? 70 : 24;
      burst    = $urandom_range(4, 2 * ring_size() + 4);
      if (burst > left) burst = left;
      repeat (burst) send_random_command(push_pct);
      left -= burst;
    end
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_command(CMD_POP_FRONT, 32'sd7);
    send_command(CMD_POP_BACK, 32'sd7);
    send_command(CMD_NONE, '0);
    for (int c = CMD_POP_BACK + 1; c < 2 ** CMD_W; c++) send_command(CMD_W'(c), EMPTY_WORD);
    send_command(CMD_PUSH_FRONT, data_t'(32'h7fff_ffff));
    send_command(CMD_PUSH_BACK, data_t'(32'h8000_0000));
    send_command(CMD_PUSH_FRONT, EMPTY_WORD);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_FRONT, '0);
    write_capacity(cap_t'(1));
    send_command(CMD_PUSH_BACK, data_t'(32'h1234_5678));
    send_command(CMD_PUSH_FRONT, 32'sd1);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_FRONT, '0);
    write_capacity('0);
    send_command(CMD_PUSH_FRONT, 32'sd5);
    send_command(CMD_PUSH_BACK, 32'sd6);
    write_capacity('1);
    send_command(CMD_PUSH_BACK, data_t'(32'h5555_aaaa));
    write_capacity(cap_t'(3));
    send_command(CMD_POP_FRONT, '0);
  endtask

  task automatic test_random_traffic();
    int send_pct [4] = '{0, 88, 0, 8};
    int recv_pct [4] = '{0, 0, 88, 8};
    for (int m = 0; m < 4; m++) begin
      set_idling(send_pct[m], recv_pct[m]);
      run_traffic(120, cap_t'(1));
      run_traffic(120, cap_t'($urandom_range(2, 8)));
      run_traffic(120, cap_t'(DEPTH));
      run_traffic(120, cap_t'($urandom_range(0, 2 ** CAP_W - 1)));
    end
  endtask

  task automatic test_output_backpressure();
    set_idling(0, 0);
    write_capacity(cap_t'(4));
    recv_hold_cycles = 400;
    repeat (30) send_random_command(60);
  endtask

  task automatic test_sender_pause();
    set_idling(8, 8);
    write_capacity(cap_t'(5));
    repeat (10) send_random_command(60);
    release_sender();
    wait_drained();
    repeat (10) send_random_command(40);
  endtask

  initial begin
    rst_n            <= 1'b0;
    cmd_if.valid     <= 1'b0;
    cmd_if.command   <= CMD_NONE;
    cmd_if.value     <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.capacity  <= '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    recv_hold_cycles = 0;
    mismatches       = 0;
    commands_sent    = 0;
    statuses_checked = 0;
    refused_count    = 0;
    full_count       = 0;
    foreach (ring_copy[i]) ring_copy[i] = '0;
    capacity_reg = cap_t'(DEPTH);
    clear_ring();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();

    release_sender();
    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_status_q.size() != 0)
      report_mismatch("statuses left pending", pending_status_q.size(), 0);

    $display("Sent %0d commands and checked %0d statuses, %0d refused and %0d ending full,",
             commands_sent, statuses_checked, refused_count, full_count);
    $display("across capacity settings from 0 to %0d under four idling patterns and a long stall.",
             2 ** CAP_W - 1);
    if (mismatches == 0) begin
      $display("circular_deque: match");
    end else begin
      $display("circular_deque: mismatch");
    end
    $finish;
  end

endmodule
